// File: rtl/gic_pkg.sv
// Package for the greedy implicant cover unit.
// Holds the sizes, command codes, sequencer states and the popcount helper.
// Depends on nothing; every other file in rtl/ imports it.
package gic_pkg;

  // Number of function variables and the minterm space they span.
  localparam int NumVars    = 6;
  localparam int MaskW      = 64;
  localparam int Span       = 1 << NumVars;
  localparam logic [MaskW-1:0] MintermSpace =
      (Span >= MaskW) ? {MaskW{1'b1}} : ((64'd1 << Span) - 64'd1);

  // Prime table geometry.
  localparam int MaxPrimes  = 32;
  localparam int IdxW       = (MaxPrimes > 1) ? $clog2(MaxPrimes) : 1;
  localparam int CntW       = $clog2(MaxPrimes + 1);

  // Result cap per run and the width of the result counter.
  localparam int ResultCap  = 32;
  localparam int ResW       = $clog2(ResultCap + 1);

  // Output index field width and popcount width.
  localparam int OutIdxW    = 5;
  localparam int PopW       = $clog2(MaskW + 1);

  typedef logic [MaskW-1:0] mask_t;

  // Command codes carried by func.
  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_RUN   = 2'd1,
    FUNC_CLEAR = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SCAN   = 2'd1,
    ST_DECIDE = 2'd2,
    ST_FLUSH  = 2'd3
  } state_e;

  // Population count: eight independent byte counts, then their sum.
  function automatic logic [PopW-1:0] popcount(input mask_t v);
    logic [3:0]      byte_cnt [MaskW/8];
    logic [PopW-1:0] total;
    total = '0;
    for (int b = 0; b < MaskW / 8; b++) begin
      byte_cnt[b] = '0;
      for (int k = 0; k < 8; k++) begin
        byte_cnt[b] = byte_cnt[b] + {3'd0, v[b*8+k]};
      end
    end
    for (int b = 0; b < MaskW / 8; b++) begin
      total = total + PopW'(byte_cnt[b]);
    end
    return total;
  endfunction

endpackage

// File: rtl/gic_cover_ram.sv
// Cover mask memory of the greedy implicant cover unit.
// One write port and one registered read port; depends on gic_pkg.
module gic_cover_ram (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [gic_pkg::IdxW-1:0] waddr_i,
  input  gic_pkg::mask_t       wdata_i,
  input  logic [gic_pkg::IdxW-1:0] raddr_i,
  output gic_pkg::mask_t       rdata_o
);
  import gic_pkg::*;

  mask_t mem_q [MaxPrimes];
  mask_t rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/gic_score.sv
// Shared scoring unit of the greedy implicant cover unit.
// Counts the uncovered minterms one prime covers and compares against the best
// so far; depends on gic_pkg.
module gic_score (
  input  gic_pkg::mask_t              cover_i,
  input  gic_pkg::mask_t              work_i,
  input  logic                        valid_i,
  input  logic                        chosen_i,
  input  logic [gic_pkg::PopW-1:0]    best_cnt_i,
  output logic [gic_pkg::PopW-1:0]    cnt_o,
  output logic                        better_o
);
  import gic_pkg::*;

  // Score of this prime against the current uncovered set.
  assign cnt_o = popcount(cover_i & work_i);

  // Strictly greater keeps ties on the lowest index.
  assign better_o = valid_i && !chosen_i && (cnt_o > best_cnt_i);

endmodule

// File: rtl/greedy_implicant_cover_unit.sv
// Top level of the greedy implicant cover unit.
// Instantiates gic_cover_ram and gic_score; depends on gic_pkg.

// Load and clear commands complete in the cycle they are taken and keep busy
// low. A run holds busy high while the sequencer repeats greedy steps: each
// step scans the stored primes through the single memory read port and the
// shared popcount/compare unit, one prime per cycle. A run takes one step per
// selection, one more step when it ends below the cap of 32 results, and a
// pass through the flush state when it made any selection. Each result
// transaction is shown for exactly one cycle on result_valid_o and cannot be
// held off; a result is held until the sequencer knows whether it is the last
// one, so results of a run arrive spaced by one scan, but for the last result
// of a run that reaches the cap, which the flush state releases.
module greedy_implicant_cover_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic [63:0]                   minterm_mask_i,
  input  logic                          already_chosen_i,
  output logic                          result_valid_o,
  output logic [gic_pkg::OutIdxW-1:0]   prime_index_o,
  output logic                          selected_o,
  output logic [63:0]                   removed_mask_o,
  output logic                          still_uncovered_o,
  output logic                          last_o
);
  import gic_pkg::*;

  state_e              state_q, state_d;
  logic [CntW-1:0]     count_q;
  logic [MaxPrimes-1:0] chosen_q;
  mask_t               work_q, work_d;
  logic [CntW-1:0]     rd_addr_q, rd_addr_d;
  logic                ev_valid_q, ev_valid_d;
  logic [IdxW-1:0]     ev_idx_q;
  logic [PopW-1:0]     best_cnt_q, best_cnt_d;
  logic [IdxW-1:0]     best_idx_q, best_idx_d;
  mask_t               best_mask_q, best_mask_d;
  logic [ResW-1:0]     n_q, n_d;
  logic                pend_q, pend_d;
  logic [IdxW-1:0]     pend_idx_q, pend_idx_d;
  mask_t               pend_mask_q, pend_mask_d;
  logic                set_chosen;

  logic                accept;
  func_e               func;
  logic                load_we;
  mask_t               rdata;
  logic [PopW-1:0]     score_cnt;
  logic                score_better;

  // Result emission signals and output registers.
  logic                emit;
  logic [IdxW-1:0]     emit_idx;
  logic                emit_sel;
  mask_t               emit_mask;
  logic                emit_still;
  logic                emit_last;
  logic                res_valid_q;
  logic [IdxW-1:0]     res_idx_q;
  logic                res_sel_q;
  mask_t               res_mask_q;
  logic                res_still_q;
  logic                res_last_q;

  assign busy    = (state_q != ST_IDLE);
  assign accept  = start && !busy;
  assign func    = func_e'(func_i);
  assign load_we = accept && (func == FUNC_LOAD) && (count_q < CntW'(MaxPrimes));

  gic_cover_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (minterm_mask_i & MintermSpace),
    .raddr_i (rd_addr_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  gic_score u_score (
    .cover_i    (rdata),
    .work_i     (work_q),
    .valid_i    (ev_valid_q),
    .chosen_i   (chosen_q[ev_idx_q]),
    .best_cnt_i (best_cnt_q),
    .cnt_o      (score_cnt),
    .better_o   (score_better)
  );

  // Sequencer: next state, datapath updates and result emission.
  always_comb begin
    state_d     = state_q;
    work_d      = work_q;
    rd_addr_d   = rd_addr_q;
    ev_valid_d  = 1'b0;
    best_cnt_d  = best_cnt_q;
    best_idx_d  = best_idx_q;
    best_mask_d = best_mask_q;
    n_d         = n_q;
    pend_d      = pend_q;
    pend_idx_d  = pend_idx_q;
    pend_mask_d = pend_mask_q;
    set_chosen  = 1'b0;
    emit        = 1'b0;
    emit_idx    = pend_idx_q;
    emit_sel    = 1'b1;
    emit_mask   = pend_mask_q;
    emit_still  = 1'b0;
    emit_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept && (func == FUNC_RUN)) begin
          work_d     = minterm_mask_i & MintermSpace;
          rd_addr_d  = '0;
          best_cnt_d = '0;
          best_idx_d = '0;
          n_d        = '0;
          pend_d     = 1'b0;
          state_d    = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // Issue one read per cycle; score the previous read.
        if (rd_addr_q < count_q) begin
          ev_valid_d = 1'b1;
          rd_addr_d  = rd_addr_q + CntW'(1);
        end
        if (score_better) begin
          best_cnt_d  = score_cnt;
          best_idx_d  = ev_idx_q;
          best_mask_d = rdata;
        end
        if ((rd_addr_q == count_q) && !ev_valid_q) begin
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        if (best_cnt_q != '0) begin
          // Release the held result; this one becomes the held one.
          emit        = pend_q;
          set_chosen  = 1'b1;
          work_d      = work_q & ~best_mask_q;
          pend_d      = 1'b1;
          pend_idx_d  = best_idx_q;
          pend_mask_d = best_mask_q & work_q;
          n_d         = n_q + ResW'(1);
          if (n_q == ResW'(ResultCap - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            rd_addr_d  = '0;
            best_cnt_d = '0;
            best_idx_d = '0;
            state_d    = ST_SCAN;
          end
        end else if (pend_q) begin
          state_d = ST_FLUSH;
        end else begin
          // No selection was possible in this run.
          emit       = 1'b1;
          emit_idx   = '0;
          emit_sel   = 1'b0;
          emit_mask  = '0;
          emit_still = (work_q != '0);
          emit_last  = 1'b1;
          state_d    = ST_IDLE;
        end
      end

      ST_FLUSH: begin
        emit       = 1'b1;
        emit_still = (work_q != '0);
        emit_last  = 1'b1;
        pend_d     = 1'b0;
        state_d    = ST_IDLE;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      chosen_q    <= '0;
      work_q      <= '0;
      rd_addr_q   <= '0;
      ev_valid_q  <= 1'b0;
      best_cnt_q  <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      work_q      <= work_d;
      rd_addr_q   <= rd_addr_d;
      ev_valid_q  <= ev_valid_d;
      best_cnt_q  <= best_cnt_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      res_valid_q <= emit;
      if (load_we) begin
        count_q                      <= count_q + CntW'(1);
        chosen_q[count_q[IdxW-1:0]]  <= already_chosen_i;
      end else if (accept && (func == FUNC_CLEAR)) begin
        count_q  <= '0;
        chosen_q <= '0;
      end else if (set_chosen) begin
        chosen_q[best_idx_q] <= 1'b1;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    ev_idx_q    <= rd_addr_q[IdxW-1:0];
    best_idx_q  <= best_idx_d;
    best_mask_q <= best_mask_d;
    pend_idx_q  <= pend_idx_d;
    pend_mask_q <= pend_mask_d;
    if (emit) begin
      res_idx_q   <= emit_idx;
      res_sel_q   <= emit_sel;
      res_mask_q  <= emit_mask;
      res_still_q <= emit_still;
      res_last_q  <= emit_last;
    end
  end

  assign result_valid_o    = res_valid_q;
  assign prime_index_o     = OutIdxW'(res_idx_q);
  assign selected_o        = res_sel_q;
  assign removed_mask_o    = res_mask_q;
  assign still_uncovered_o = res_still_q;
  assign last_o            = res_last_q;

endmodule

// File: bench/testbench.sv
// Self-checking testbench for greedy_implicant_cover_unit.
// Drives load, run and clear commands and checks every result against a greedy-cover predictor,
// or a typed-in no-selection result. Depends on gic_pkg and the RTL under rtl/.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import gic_pkg::*;

  localparam int    TargetItems = 420;
  localparam int    CalmTail    = 60;
  localparam int    RunLatency  = 1200;
  localparam int    CycleLimit  = 2_000_000;
  localparam mask_t FullMask    = '1;

  // One result transaction: the prime picked in one greedy step, or the no-selection result of a run.
  typedef struct packed {
    logic [OutIdxW-1:0] prime_idx;
    logic               picked;
    mask_t              removed;
    logic               still_open;
    logic               is_last;
  } cover_step_t;

  // One row of the directed table; fixed rows carry a no-selection result typed in.
  typedef struct {
    func_e f;
    mask_t m;
    logic  c;
    bit    fixed;
    logic  fixed_still;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  func_i = FUNC_NONE;
  mask_t       minterm_mask_i = '0;
  logic        already_chosen_i = 1'b0;
  logic        result_valid_o;
  logic [OutIdxW-1:0] prime_index_o;
  logic        selected_o;
  mask_t       removed_mask_o;
  logic        still_uncovered_o;
  logic        last_o;

  // Predictor copy of the prime table.
  mask_t       cover_tab [MaxPrimes];
  logic        taken_tab [MaxPrimes];
  int          table_used = 0;

  cover_step_t cover_expect [$];
  stim_row_t   directed_rows [$];
  int          mismatch_count = 0;
  int          counted_items = 0;
  int          cycle_count = 0;
  bit          idle_on = 1'b1;

  greedy_implicant_cover_unit u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (func_i),
    .minterm_mask_i   (minterm_mask_i),
    .already_chosen_i (already_chosen_i),
    .result_valid_o   (result_valid_o),
    .prime_index_o    (prime_index_o),
    .selected_o       (selected_o),
    .removed_mask_o   (removed_mask_o),
    .still_uncovered_o(still_uncovered_o),
    .last_o           (last_o)
  );

  always #5 clk_i = ~clk_i;

  // Applies one command to the predicted table. Returns 1 unless the block ignores it.
  function automatic bit predict_cover(input func_e f, input mask_t m, input logic c,
                                       input bit keep);
    cover_step_t run_steps [$];
    cover_step_t step;
    mask_t       left;
    int          best_cnt;
    int          best_idx;
    int          cnt;
    bit          takes_effect;
    left = m & MintermSpace;
    takes_effect = 1'b1;
    case (f)
      FUNC_LOAD: begin
        if (table_used < MaxPrimes) begin
          cover_tab[table_used] = left;
          taken_tab[table_used] = c;
          table_used++;
        end else begin
          takes_effect = 1'b0;
        end
      end
      FUNC_CLEAR: begin
        foreach (taken_tab[i]) taken_tab[i] = 1'b0;
        table_used = 0;
      end
      FUNC_RUN: begin
        // Greedy steps: largest overlap wins, the strict compare keeps the lowest index.
        while (run_steps.size() < ResultCap) begin
          best_cnt = 0;
          best_idx = 0;
          for (int i = 0; i < table_used; i++) begin
            cnt = $countones(cover_tab[i] & left);
            if (!taken_tab[i] && cnt > best_cnt) begin
              best_cnt = cnt;
              best_idx = i;
            end
          end
          if (best_cnt == 0) break;
          taken_tab[best_idx] = 1'b1;
          step.prime_idx  = OutIdxW'(best_idx);
          step.picked     = 1'b1;
          step.removed    = cover_tab[best_idx] & left;
          step.still_open = 1'b0;
          step.is_last    = 1'b0;
          left &= ~step.removed;
          run_steps.push_back(step);
        end
        if (run_steps.size() == 0) begin
          step = '{prime_idx: '0, picked: 1'b0, removed: '0,
                   still_open: (left != '0), is_last: 1'b1};
        end else begin
          step = run_steps.pop_back();
          step.still_open = (left != '0);
          step.is_last    = 1'b1;
        end
        run_steps.push_back(step);
        if (keep) begin
          foreach (run_steps[i]) cover_expect.push_back(run_steps[i]);
        end
      end
      default: takes_effect = 1'b0;
    endcase
    return takes_effect;
  endfunction

  function automatic mask_t random_mask(input bit dense);
    mask_t r;
    int    lo;
    int    hi;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: r = r & {$urandom, $urandom} & {$urandom, $urandom};
      1: begin
        lo = $urandom_range(0, 63);
        hi = $urandom_range(lo, 63);
        r = (FullMask << lo) & (FullMask >> (63 - hi));
      end
      2: r = mask_t'(1) << $urandom_range(0, 63);
      3: r = dense ? FullMask : '0;
      default: ;
    endcase
    if (dense && $urandom_range(0, 1) == 1) r |= {$urandom, $urandom};
    return r;
  endfunction

  task automatic add_row(input func_e f, input mask_t m, input logic c,
                         input bit fixed = 1'b0, input logic fixed_still = 1'b0);
    stim_row_t row;
    row = '{f: f, m: m, c: c, fixed: fixed, fixed_still: fixed_still};
    directed_rows.push_back(row);
  endtask

  // Presents one command and holds it until the block takes it.
  task automatic send_item(input func_e f, input mask_t m, input logic c,
                           input bit fixed = 1'b0, input logic fixed_still = 1'b0);
    cover_step_t want;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    start            <= 1'b1;
    func_i           <= f;
    minterm_mask_i   <= m;
    already_chosen_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
    counted_items += predict_cover(f, m, c, !fixed);
    if (fixed) begin
      want = '{prime_idx: '0, picked: 1'b0, removed: '0,
               still_open: fixed_still, is_last: 1'b1};
      cover_expect.push_back(want);
    end
  endtask

  // Stops sending until every predicted result has come back.
  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk_i); while (cover_expect.size() != 0);
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatch_count < 10) $display("MISMATCH: %s", msg);
    mismatch_count++;
  endtask

  // Result checker: each strobed transaction against the oldest expectation.
  always @(posedge clk_i) begin : result_check
    cover_step_t got;
    cover_step_t want;
    if (rst_ni && result_valid_o === 1'b1) begin
      got = '{prime_idx: prime_index_o, picked: selected_o, removed: removed_mask_o,
              still_open: still_uncovered_o, is_last: last_o};
      if (cover_expect.size() == 0) begin
        note_mismatch($sformatf("unexpected result idx=%0d sel=%b rem=%h still=%b last=%b",
                                got.prime_idx, got.picked, got.removed, got.still_open,
                                got.is_last));
      end else begin
        want = cover_expect.pop_front();
        if (got !== want) begin
          note_mismatch($sformatf(
              "exp idx=%0d sel=%b rem=%h still=%b last=%b, got idx=%0d sel=%b rem=%h still=%b last=%b",
              want.prime_idx, want.picked, want.removed, want.still_open, want.is_last,
              got.prime_idx, got.picked, got.removed, got.still_open, got.is_last));
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int   base;
    int   n_loads;
    bit   single_bits;
    foreach (taken_tab[i]) taken_tab[i] = 1'b0;

    // Directed commands: empty table, ignored code, essential prime, ties, persistence.
    add_row(FUNC_RUN,   '0, 1'b0, 1'b1, 1'b0);
    add_row(FUNC_RUN,   FullMask, 1'b1, 1'b1, 1'b1);
    add_row(FUNC_NONE,  FullMask, 1'b1);
    add_row(FUNC_LOAD,  FullMask, 1'b1);
    add_row(FUNC_RUN,   FullMask, 1'b0, 1'b1, 1'b1);
    add_row(FUNC_LOAD,  64'h0000_0000_0000_00f0, 1'b0);
    add_row(FUNC_LOAD,  64'h0000_0000_0000_000f, 1'b0);
    add_row(FUNC_LOAD,  64'hffff_0000_0000_0000, 1'b0);
    add_row(FUNC_LOAD,  64'h8000_0000_0000_0001, 1'b0);
    add_row(FUNC_RUN,   64'hffff_0000_0000_00ff, 1'b0);
    add_row(FUNC_RUN,   FullMask, 1'b0);
    add_row(FUNC_RUN,   FullMask, 1'b0, 1'b1, 1'b1);
    add_row(FUNC_CLEAR, FullMask, 1'b1);
    add_row(FUNC_RUN,   FullMask, 1'b0, 1'b1, 1'b1);
    add_row(FUNC_LOAD,  '0, 1'b0);
    add_row(FUNC_LOAD,  64'h5555_5555_5555_5555, 1'b0);
    add_row(FUNC_LOAD,  64'haaaa_aaaa_aaaa_aaaa, 1'b0);
    add_row(FUNC_LOAD,  64'haaaa_aaaa_aaaa_aaaa, 1'b1);
    add_row(FUNC_RUN,   '0, 1'b1, 1'b1, 1'b0);
    add_row(FUNC_RUN,   FullMask, 1'b1);
    add_row(FUNC_NONE,  '0, 1'b0);
    add_row(FUNC_CLEAR, '0, 1'b0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].f, directed_rows[i].m, directed_rows[i].c,
                directed_rows[i].fixed, directed_rows[i].fixed_still);
    end
    drain_results();

    // Random scenarios: mostly clear, fill, run; some full tables, some noise.
    for (int scen = 0; counted_items < TargetItems; scen++) begin
      idle_on = (counted_items < TargetItems - CalmTail);
      if (scen == 0 || $urandom_range(0, 9) == 0) begin
        // Full table; with single-minterm primes the run hits the result cap.
        single_bits = (scen == 0) || ($urandom_range(0, 1) == 1);
        send_item(FUNC_CLEAR, random_mask(0), 1'($urandom_range(0, 1)));
        base = $urandom_range(0, 63);
        for (int k = 0; k < MaxPrimes; k++) begin
          if (single_bits) begin
            send_item(FUNC_LOAD, mask_t'(1) << ((base + k) % 64), 1'b0);
          end else begin
            send_item(FUNC_LOAD, random_mask(0), 1'($urandom_range(0, 5) == 0));
          end
        end
        repeat ($urandom_range(1, 2)) begin
          send_item(FUNC_LOAD, random_mask(0), 1'($urandom_range(0, 1)));
        end
        send_item(FUNC_RUN, FullMask, 1'($urandom_range(0, 1)));
        send_item(FUNC_RUN, random_mask(1), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) != 0) begin
          send_item(FUNC_CLEAR, random_mask(0), 1'($urandom_range(0, 1)));
        end
        n_loads = $urandom_range(0, 12);
        for (int k = 0; k < n_loads; k++) begin
          send_item(FUNC_LOAD, random_mask(0), 1'($urandom_range(0, 4) == 0));
        end
        repeat ($urandom_range(1, 3)) begin
          send_item(FUNC_RUN, random_mask(1), 1'($urandom_range(0, 1)));
        end
      end
      if ($urandom_range(0, 7) == 0) begin
        send_item(FUNC_NONE, random_mask(0), 1'($urandom_range(0, 1)));
      end
      if ($urandom_range(0, 5) == 0) drain_results();
    end

    // Wind down: all results back, then a quiet stretch for strays.
    drain_results();
    repeat (RunLatency) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
